[src/rwnh_pkg.sv]
// Package for the ray and wall nearest-hit block: beat types, constants, states.
// Used by every file under src; depends on nothing.
package rwnh_pkg;
  localparam int MaxWallsDefault = 64;
  localparam int FractionBitsDefault = 4;
  localparam int ProdW = 34;
  localparam int DetW = 35;
  localparam int QuotW = 17;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_PROBE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] point_a_x;
    logic signed [15:0] point_a_y;
    logic signed [15:0] point_b_x;
    logic signed [15:0] point_b_y;
  } in_beat_t;

  typedef struct packed {
    logic               hit;
    logic        [14:0] distance;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic               status;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_TEST, ST_DIVX, ST_DIVY,
    ST_CMP, ST_SQRT, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [69:0] num;
    logic [35:0] den;
  } div_req_t;
endpackage

[src/ray_wall_nearest_hit_top.sv]
// Top level of the ray and wall nearest-hit block: wall memory, sequencer, sqrt.
// Depends on rwnh_pkg and rwnh_div.
//
// A store beat is answered in the cycle after it is taken, and the input stays
// stalled until that result is taken. A probe walks the stored walls one at a
// time through a single synchronous memory port. A missed wall passes through
// ST_READ, ST_MUL1, ST_MUL2 and ST_TEST; a crossed wall goes on through ST_DIVX,
// ST_DIVY and ST_CMP and spends most of its time in the two divisions for the
// offsets. The walk ends with one more pass through ST_READ, a square root when
// a wall was crossed, and ST_OUT to present the result. The shared serial
// divider dominates the cost of a probe.
module ray_wall_nearest_hit_top #(
  parameter int MAX_WALLS = rwnh_pkg::MaxWallsDefault,
  parameter int FRACTION_BITS = rwnh_pkg::FractionBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rwnh_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rwnh_pkg::out_beat_t out_data
);
  import rwnh_pkg::*;

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam longint NoHitRaw = 64'(2000) << FRACTION_BITS;
  localparam logic [14:0] NoHit = (NoHitRaw > 32767) ? 15'h7fff : 15'(NoHitRaw);

  logic [63:0] mem [MAX_WALLS];
  logic [63:0] rdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  state_t state, state_next;
  in_beat_t cur;
  logic signed [16:0] dx, dy, wx, wy, ox, oy;
  logic signed [33:0] p0, p1, p2, p3, p4, p5;
  logic signed [DetW-1:0] d, na, nb;
  logic found;
  logic [33:0] best_sq;
  logic signed [16:0] offx, offy;
  logic signed [15:0] best_x, best_y;
  div_req_t dreq;
  logic dbusy, dstart;
  logic [69:0] dquot;
  logic [33:0] sq;
  logic [33:0] sx;
  logic [35:0] root;
  logic [35:0] root_rnd;
  logic [5:0] scnt;
  logic [35:0] sbit;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_data.cmd == CMD_STORE && count < CW'(MAX_WALLS))
      mem[count[AW-1:0]] <= {in_data.point_b_y, in_data.point_b_x,
                             in_data.point_a_y, in_data.point_a_x};
    rdata <= mem[raddr];
  end
  assign raddr = idx[AW-1:0];

  rwnh_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dquot));

  assign in_stall = (state != ST_IDLE) || out_valid;

  always_comb begin
    state_next = state;
    dstart = 1'b0;
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall && in_data.cmd == CMD_PROBE) state_next = ST_READ;
      ST_READ: state_next = (idx >= count) ? ST_SQRT : ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_TEST;
      ST_TEST: begin
        if (d == 0 || na < 0 || na >= d || nb < 0 || nb >= d) state_next = ST_READ;
        else begin
          state_next = ST_DIVX;
          dstart = 1'b1;
        end
      end
      ST_DIVX: if (!dbusy && !dreq.start) begin
        state_next = ST_DIVY;
        dstart = 1'b1;
      end
      ST_DIVY: if (!dbusy && !dreq.start) state_next = ST_CMP;
      ST_CMP: state_next = ST_READ;
      ST_SQRT: if (!found || scnt == 6'd0) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [16:0] mag_sel;
  assign mag_sel = (state == ST_TEST) ? (dx < 0 ? 17'(-dx) : 17'(dx)) : (dy < 0 ? 17'(-dy) : 17'(dy));
  logic [35:0] dd2;
  assign dd2 = {d[DetW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) dreq.start <= 1'b0;
    else dreq.start <= dstart;
    if (dstart) begin
      dreq.num <= 70'(({35'd0, na[DetW-1:0]} * {53'd0, mag_sel}) << 1) + 70'(d);
      dreq.den <= dd2;
    end
  end

  assign wx = 17'($signed(rdata[47:32])) - 17'($signed(rdata[15:0]));
  assign wy = 17'($signed(rdata[63:48])) - 17'($signed(rdata[31:16]));
  assign ox = 17'(cur.point_a_x) - 17'($signed(rdata[15:0]));
  assign oy = 17'(cur.point_a_y) - 17'($signed(rdata[31:16]));

  logic [33:0] cand_sq;
  assign cand_sq = 34'(offx * offx) + 34'(offy * offy);

  assign root_rnd = ({2'b0, sx} > root) ? root + 36'd1 : root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          cur <= in_data;
          idx <= '0;
          found <= 1'b0;
          if (in_data.cmd == CMD_STORE) begin
            out_valid <= 1'b1;
            out_data.hit <= 1'b0;
            out_data.distance <= '0;
            out_data.hit_x <= '0;
            out_data.hit_y <= '0;
            if (count < CW'(MAX_WALLS)) begin
              count <= count + 1'b1;
              out_data.status <= 1'b0;
            end else begin
              out_data.status <= 1'b1;
            end
          end else begin
            dx <= 17'(in_data.point_b_x) - 17'(in_data.point_a_x);
            dy <= 17'(in_data.point_b_y) - 17'(in_data.point_a_y);
          end
        end
        ST_READ: if (idx < count) idx <= idx + 1'b1;
        ST_MUL1: begin
          p0 <= wy * dx; p1 <= wx * dy; p2 <= wx * oy;
          p3 <= wy * ox; p4 <= dx * oy; p5 <= dy * ox;
        end
        ST_MUL2: begin
          if (35'(p0) - 35'(p1) < 0) begin
            d <= 35'(p1) - 35'(p0); na <= 35'(p3) - 35'(p2); nb <= 35'(p5) - 35'(p4);
          end else begin
            d <= 35'(p0) - 35'(p1); na <= 35'(p2) - 35'(p3); nb <= 35'(p4) - 35'(p5);
          end
        end
        ST_DIVX: if (!dbusy && !dreq.start) offx <= dx < 0 ? -17'(dquot[16:0]) : 17'(dquot[16:0]);
        ST_DIVY: if (!dbusy && !dreq.start) offy <= dy < 0 ? -17'(dquot[16:0]) : 17'(dquot[16:0]);
        ST_CMP: if (!found || cand_sq < best_sq) begin
          found <= 1'b1;
          best_sq <= cand_sq;
          best_x <= 16'(17'(cur.point_a_x) + offx);
          best_y <= 16'(17'(cur.point_a_y) + offy);
          sx <= cand_sq;
          root <= '0;
          sbit <= 36'd1 << 34;
          scnt <= 6'd18;
        end
        ST_SQRT: if (found && scnt != 6'd0) begin
          if ({2'b0, sx} >= root + sbit) begin
            sx <= 34'({2'b0, sx} - (root + sbit));
            root <= (root >> 1) + sbit;
          end else root <= root >> 1;
          sbit <= sbit >> 2;
          scnt <= scnt - 6'd1;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          out_data.status <= 1'b0;
          out_data.hit <= found;
          if (found) begin
            out_data.distance <= (root_rnd > 36'(NoHit)) ? NoHit : root_rnd[14:0];
            out_data.hit_x <= best_x;
            out_data.hit_y <= best_y;
          end else begin
            out_data.distance <= NoHit;
            out_data.hit_x <= '0;
            out_data.hit_y <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // The sqrt is seeded in ST_CMP with every new best, so sx/root track best_sq.
  assign sq = best_sq;

  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_WALLS))
    else $error("wall count beyond table");
  a_stall: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while a result waits");
  a_idx: assert property (@(posedge clk) disable iff (rst) idx <= count)
    else $error("walk index beyond count");
  a_sq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && found && scnt == 6'd18) |-> sx == sq)
    else $error("root not seeded from best");
endmodule

[src/rwnh_div.sv]
// Restoring divider, one quotient bit a cycle, for the hit offset magnitude.
// Depends on rwnh_pkg.
module rwnh_div (
  input  logic            clk,
  input  logic            rst,
  input  rwnh_pkg::div_req_t req,
  output logic            busy,
  output logic [69:0]     quot
);
  import rwnh_pkg::*;

  logic [69:0] rem;
  logic [35:0] den;
  logic [6:0]  cnt;
  logic [70:0] trial;

  always_comb begin
    trial = {rem, quot[69]} - {35'd0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd70;
      rem <= '0;
      quot <= req.num;
      den <= req.den;
    end else if (busy) begin
      if (!trial[70]) begin
        rem <= trial[69:0];
        quot <= {quot[68:0], 1'b1};
      end else begin
        rem <= {rem[68:0], quot[69]};
        quot <= {quot[68:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
